/* design/multi_flow_go_back_n_receiver_top_defines.svh */
// Assertion macros for the multi-flow go-back-N receiver.
// Included by the modules that check their own logic; no other dependencies.
`ifndef MULTI_FLOW_GO_BACK_N_RECEIVER_TOP_DEFINES_SVH
`define MULTI_FLOW_GO_BACK_N_RECEIVER_TOP_DEFINES_SVH
`ifndef SYNTH
// Whenever ante holds, cons holds in the same cycle.
`define MFGBN_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Whenever ante holds, cons holds in the following cycle.
`define MFGBN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
// cond never holds.
`define MFGBN_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);
`else
`define MFGBN_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`define MFGBN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`define MFGBN_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

/* design/mfgbn_pkg.sv */
// Shared types, codes and constants of the multi-flow go-back-N receiver.
// No dependencies; imported by every module of the block.
`default_nettype none

package mfgbn_pkg;

  // Flow table geometry
  localparam int FLOW_COUNT = 256;
  localparam int FLOW_IW    = (FLOW_COUNT > 1) ? $clog2(FLOW_COUNT) : 1;
  localparam int OPEN_W     = $clog2(FLOW_COUNT + 1);

  // Command queue between front and back
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_PW    = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int MAX_RES    = 3;

  // Random numbers are taken modulo this span
  localparam logic [14:0] RAND_SPAN = 15'h7FFF;

  // Received header types
  localparam logic [2:0] PKT_DATA = 3'd0;
  localparam logic [2:0] PKT_SYN  = 3'd1;
  localparam logic [2:0] PKT_ACK  = 3'd2;
  localparam logic [2:0] PKT_FIN  = 3'd3;
  localparam logic [2:0] PKT_RST  = 3'd4;

  // Result kinds
  localparam logic [1:0] KIND_REPLY    = 2'd0;
  localparam logic [1:0] KIND_DELIVER  = 2'd1;
  localparam logic [1:0] KIND_CLOSED   = 2'd2;
  localparam logic [1:0] KIND_SHUTDOWN = 2'd3;

  // Reply types
  localparam logic [1:0] RT_ACK    = 2'd0;
  localparam logic [1:0] RT_SYNACK = 2'd1;
  localparam logic [1:0] RT_FIN    = 2'd2;

  typedef enum logic [1:0] {
    ST_DISC   = 2'd0,
    ST_WOPEN  = 2'd1,
    ST_WCLOSE = 2'd2,
    ST_EST    = 2'd3
  } flow_st_t;

  typedef enum logic {
    FS_IDLE = 1'b0,
    FS_EXEC = 1'b1
  } front_state_t;

  typedef struct packed {
    logic [7:0]  flow_id;
    logic [2:0]  pkt_type;
    logic [15:0] seq_num;
    logic [15:0] ack_num;
    logic [7:0]  window_size;
    logic        ecn_bit;
    logic [14:0] random_seq;
  } hdr_t;

  typedef struct packed {
    flow_st_t    st;
    logic [15:0] exp_seq;
    logic [15:0] win_end;
    logic [7:0]  held;
  } tbl_entry_t;

  typedef struct packed {
    logic               rd_en;
    logic [FLOW_IW-1:0] rd_addr;
    logic               wr_en;
    logic [FLOW_IW-1:0] wr_addr;
    tbl_entry_t         wr_data;
  } tbl_req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  rtype;
    logic [7:0]  flow;
    logic [15:0] seq;
    logic [15:0] ack;
    logic [7:0]  win;
    logic        ecn;
  } result_t;

  typedef struct packed {
    logic [1:0]                 cnt;
    result_t [MAX_RES-1:0]      res;
  } cmd_t;

endpackage

`default_nettype wire

/* design/multi_flow_go_back_n_receiver_top.sv */
// Top level of the multi-flow go-back-N receiver.
// Depends on mfgbn_pkg, mfgbn_flow_table, mfgbn_front and mfgbn_back.
//
// Usage
//   Headers arrive on a queue-style input: a transfer takes place on a clock edge
//   with push high and full low. Results leave on a queue-style output: while empty
//   is low the oldest result sits on the out_ ports, and pop with empty low takes it.
//   Each header yields zero to three results; out_last_result marks the final one.
//   Timing
//   A header's flow entry is read at its transfer edge and worked on in the following
//   cycle in execute; it is written back when the front leaves execute, which it does
//   only once the command queue can take the results. The front then returns to idle,
//   so the input takes no new header while one is in execute. Its first result is on
//   the out_ ports once its command is in the queue and older results have left, and
//   can be popped from then on. Results leave at one per cycle while pop is held high;
//   the table read-modify-write and the result serialiser set the throughput.
//   Reset
//   rst_n (synchronous, active low) marks every table entry as disconnected at once
//   through per-flow valid bits, zeroes the open flow count and empties the queue.
//   Stalls
//   If pop stays low, up to two headers' results wait in the command queue; then the
//   front holds its pending header and full stays high until space frees up.
`default_nettype none

module multi_flow_go_back_n_receiver_top
  import mfgbn_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_flow_id,
  input  logic [2:0]  in_pkt_type,
  input  logic [15:0] in_seq_num,
  input  logic [15:0] in_ack_num,
  input  logic [7:0]  in_window_size,
  input  logic        in_ecn_bit,
  input  logic [14:0] in_random_seq,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  out_result_kind,
  output logic [1:0]  out_reply_type,
  output logic [7:0]  out_flow,
  output logic [15:0] out_seq,
  output logic [15:0] out_ack,
  output logic [7:0]  out_window,
  output logic        out_ecn,
  output logic        out_last_result
);

  hdr_t       hdr;
  tbl_req_t   tbl_req;
  tbl_entry_t tbl_rd;
  cmd_t       cmd;
  logic       cmd_valid;
  logic       cmd_ready;
  result_t    res;

  // Gather the header fields
  assign hdr.flow_id     = in_flow_id;
  assign hdr.pkt_type    = in_pkt_type;
  assign hdr.seq_num     = in_seq_num;
  assign hdr.ack_num     = in_ack_num;
  assign hdr.window_size = in_window_size;
  assign hdr.ecn_bit     = in_ecn_bit;
  assign hdr.random_seq  = in_random_seq;

  mfgbn_flow_table u_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_i     (tbl_req),
    .rd_data_o (tbl_rd)
  );

  mfgbn_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .hdr_push_i  (push),
    .hdr_i       (hdr),
    .hdr_full_o  (full),
    .tbl_req_o   (tbl_req),
    .tbl_rd_i    (tbl_rd),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_ready_i (cmd_ready)
  );

  mfgbn_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_ready_o (cmd_ready),
    .empty_o     (empty),
    .pop_i       (pop),
    .res_o       (res),
    .last_o      (out_last_result)
  );

  // Spread the head result over the output ports
  assign out_result_kind = res.kind;
  assign out_reply_type  = res.rtype;
  assign out_flow        = res.flow;
  assign out_seq         = res.seq;
  assign out_ack         = res.ack;
  assign out_window      = res.win;
  assign out_ecn         = res.ecn;

endmodule

`default_nettype wire

/* design/mfgbn_flow_table.sv */
// Flow table: per-flow state memory with registered read and reset-cleared valid bits.
// Depends on mfgbn_pkg.
`default_nettype none

module mfgbn_flow_table
  import mfgbn_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  tbl_req_t   req_i,
  output tbl_entry_t rd_data_o
);

  tbl_entry_t            table_mem_r [FLOW_COUNT];
  logic [FLOW_COUNT-1:0] vld_r;
  logic [FLOW_COUNT-1:0] vld_nxt;
  tbl_entry_t            rd_q_r;
  logic                  rd_vld_r;

  always_comb begin
    vld_nxt = vld_r;
    if (req_i.wr_en) begin
      vld_nxt[req_i.wr_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req_i.wr_en) begin
      table_mem_r[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_q_r   <= table_mem_r[req_i.rd_addr];
      rd_vld_r <= vld_r[req_i.rd_addr];
    end
  end

  // Unwritten entries read as the reset value
  assign rd_data_o = rd_vld_r ? rd_q_r : '0;

endmodule

`default_nettype wire

/* design/mfgbn_front.sv */
// Front end: accepts headers, looks up and updates the flow table, builds result commands.
// Depends on mfgbn_pkg and the assertion macro header.
`default_nettype none
`include "multi_flow_go_back_n_receiver_top_defines.svh"

module mfgbn_front
  import mfgbn_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       hdr_push_i,
  input  hdr_t       hdr_i,
  output logic       hdr_full_o,
  output tbl_req_t   tbl_req_o,
  input  tbl_entry_t tbl_rd_i,
  output logic       cmd_valid_o,
  output cmd_t       cmd_o,
  input  logic       cmd_ready_i
);

  front_state_t      state_r, state_nxt;
  hdr_t              hdr_r;
  logic [OPEN_W-1:0] open_r, open_nxt, open_calc;

  logic              push_go;
  logic              in_range;
  logic              match;
  logic              tbl_we;
  logic              exec_go;
  logic [15:0]       rnd16, seq1, exp_inc, s, exp2, exp2_inc, wend2;
  logic [1:0]        n;
  tbl_entry_t        ent, ent_nxt;
  cmd_t              cmd;

  function automatic result_t mk_res(input logic [1:0]  kind,
                                     input logic [1:0]  rtype,
                                     input logic [7:0]  flow,
                                     input logic [15:0] seq,
                                     input logic [15:0] ack,
                                     input logic [7:0]  win,
                                     input logic        ecn);
    result_t r;
    r.kind  = kind;
    r.rtype = rtype;
    r.flow  = flow;
    r.seq   = seq;
    r.ack   = ack;
    r.win   = win;
    r.ecn   = ecn;
    return r;
  endfunction

  assign push_go = hdr_push_i && (state_r == FS_IDLE);

  always_ff @(posedge clk) begin
    if (push_go) begin
      hdr_r <= hdr_i;
    end
  end

  // Flow step: work out the results and the updated table entry
  always_comb begin
    ent       = tbl_rd_i;
    ent_nxt   = ent;
    open_calc = open_r;
    cmd       = '0;
    n         = 2'd0;
    tbl_we    = 1'b0;
    rnd16     = {1'b0, (hdr_r.random_seq == RAND_SPAN) ? 15'd0 : hdr_r.random_seq};
    seq1      = hdr_r.seq_num + 16'd1;
    exp_inc   = ent.exp_seq + 16'd1;
    match     = (hdr_r.ack_num == exp_inc);
    in_range  = ({1'b0, hdr_r.flow_id} < 9'(FLOW_COUNT));
    s         = hdr_r.seq_num;
    exp2      = ent.exp_seq;
    exp2_inc  = ent.exp_seq + 16'd1;
    wend2     = ent.win_end;

    if ((hdr_r.pkt_type == PKT_RST) && (open_r == '0)) begin
      cmd.res[n] = mk_res(KIND_SHUTDOWN, RT_ACK, hdr_r.flow_id, 16'd0, 16'd0, 8'd0, 1'b0);
      n = n + 2'd1;
    end else if (in_range) begin
      tbl_we = 1'b1;
      case (hdr_r.pkt_type)
        PKT_SYN: begin
          if (ent.st != ST_EST) begin
            if (ent.st == ST_DISC) begin
              open_calc = open_r + OPEN_W'(1);
            end
            cmd.res[n] = mk_res(KIND_REPLY, RT_SYNACK, hdr_r.flow_id, rnd16, seq1,
                                hdr_r.window_size, hdr_r.ecn_bit);
            n = n + 2'd1;
            ent_nxt.exp_seq = rnd16;
            ent_nxt.st      = ST_WOPEN;
          end
        end
        PKT_ACK: begin
          if (ent.st == ST_WOPEN) begin
            if (match) begin
              ent_nxt.st = ST_EST;
            end else begin
              cmd.res[n] = mk_res(KIND_REPLY, RT_SYNACK, hdr_r.flow_id, rnd16, seq1,
                                  hdr_r.window_size, hdr_r.ecn_bit);
              n = n + 2'd1;
              ent_nxt.exp_seq = rnd16;
            end
          end else if (ent.st == ST_WCLOSE) begin
            if (match) begin
              cmd.res[n] = mk_res(KIND_CLOSED, RT_ACK, hdr_r.flow_id, 16'd0, 16'd0,
                                  8'd0, 1'b0);
              n = n + 2'd1;
              ent_nxt = '0;
              if (open_r != '0) begin
                open_calc = open_r - OPEN_W'(1);
              end
            end else begin
              cmd.res[n] = mk_res(KIND_REPLY, RT_ACK, hdr_r.flow_id, hdr_r.seq_num, seq1,
                                  hdr_r.window_size, hdr_r.ecn_bit);
              n = n + 2'd1;
              cmd.res[n] = mk_res(KIND_REPLY, RT_FIN, hdr_r.flow_id, rnd16, seq1,
                                  hdr_r.window_size, hdr_r.ecn_bit);
              n = n + 2'd1;
              ent_nxt.exp_seq = rnd16;
            end
          end
        end
        PKT_FIN: begin
          if (ent.st != ST_DISC) begin
            cmd.res[n] = mk_res(KIND_REPLY, RT_ACK, hdr_r.flow_id, hdr_r.seq_num, seq1,
                                hdr_r.window_size, hdr_r.ecn_bit);
            n = n + 2'd1;
            cmd.res[n] = mk_res(KIND_REPLY, RT_FIN, hdr_r.flow_id, rnd16, seq1,
                                hdr_r.window_size, hdr_r.ecn_bit);
            n = n + 2'd1;
            ent_nxt.exp_seq = rnd16;
            ent_nxt.st      = ST_WCLOSE;
          end
        end
        default: begin
          // Data, RST while flows are open, and any other type
          if (ent.st != ST_WCLOSE) begin
            if ((ent.st == ST_DISC) || (ent.st == ST_WOPEN)) begin
              if (ent.st == ST_DISC) begin
                open_calc = open_r + OPEN_W'(1);
              end
              cmd.res[n] = mk_res(KIND_REPLY, RT_SYNACK, hdr_r.flow_id, rnd16, seq1,
                                  hdr_r.window_size, hdr_r.ecn_bit);
              n = n + 2'd1;
              ent_nxt.exp_seq = rnd16;
              ent_nxt.st      = ST_WOPEN;
              s               = rnd16;
            end
            if (hdr_r.window_size == 8'd0) begin
              // Stop-and-wait
              cmd.res[n] = mk_res(KIND_DELIVER, RT_ACK, hdr_r.flow_id, hdr_r.seq_num, 16'd0,
                                  hdr_r.window_size, hdr_r.ecn_bit);
              n = n + 2'd1;
              cmd.res[n] = mk_res(KIND_REPLY, RT_ACK, hdr_r.flow_id, s, s,
                                  hdr_r.window_size, hdr_r.ecn_bit);
              n = n + 2'd1;
            end else begin
              // Go-back-N: restart the window on a new size or a size of one
              if ((hdr_r.window_size == 8'd1) || (hdr_r.window_size != ent.held)) begin
                exp2            = s;
                wend2           = s + {8'd0, hdr_r.window_size};
                ent_nxt.win_end = wend2;
                ent_nxt.held    = hdr_r.window_size;
              end else begin
                exp2  = ent_nxt.exp_seq;
                wend2 = ent.win_end;
              end
              exp2_inc = exp2 + 16'd1;
              if (s == exp2) begin
                ent_nxt.exp_seq = exp2_inc;
                cmd.res[n] = mk_res(KIND_DELIVER, RT_ACK, hdr_r.flow_id, hdr_r.seq_num,
                                    16'd0, hdr_r.window_size, hdr_r.ecn_bit);
                n = n + 2'd1;
                if (exp2_inc == wend2) begin
                  cmd.res[n] = mk_res(KIND_REPLY, RT_ACK, hdr_r.flow_id, s, exp2,
                                      hdr_r.window_size, hdr_r.ecn_bit);
                  n = n + 2'd1;
                end
              end else begin
                ent_nxt.exp_seq = exp2;
                cmd.res[n] = mk_res(KIND_REPLY, RT_ACK, hdr_r.flow_id, s,
                                    exp2 - 16'd1, hdr_r.window_size, hdr_r.ecn_bit);
                n = n + 2'd1;
              end
            end
          end
        end
      endcase
    end
    cmd.cnt = n;
  end

  // Sequencer: look up on acceptance, commit in execute once the queue can take the command
  always_comb begin
    state_nxt         = state_r;
    open_nxt          = open_r;
    hdr_full_o        = 1'b1;
    exec_go           = 1'b0;
    cmd_valid_o       = 1'b0;
    tbl_req_o         = '0;
    tbl_req_o.rd_addr = hdr_i.flow_id[FLOW_IW-1:0];
    tbl_req_o.wr_addr = hdr_r.flow_id[FLOW_IW-1:0];
    tbl_req_o.wr_data = ent_nxt;
    case (state_r)
      FS_IDLE: begin
        hdr_full_o = 1'b0;
        if (hdr_push_i) begin
          tbl_req_o.rd_en = 1'b1;
          state_nxt       = FS_EXEC;
        end
      end
      FS_EXEC: begin
        // Hold until the queue can take the command, unless there are no results
        exec_go = (cmd.cnt == 2'd0) || cmd_ready_i;
        if (exec_go) begin
          cmd_valid_o     = (cmd.cnt != 2'd0);
          tbl_req_o.wr_en = tbl_we;
          open_nxt        = open_calc;
          state_nxt       = FS_IDLE;
        end
      end
      default: begin
        state_nxt = FS_IDLE;
      end
    endcase
  end

  assign cmd_o = cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FS_IDLE;
      open_r  <= '0;
    end else begin
      state_r <= state_nxt;
      open_r  <= open_nxt;
    end
  end

  `MFGBN_ASSERT_NEXT(a_accept_to_exec, clk, rst_n, push_go, state_r == FS_EXEC, "accepted header did not enter execute")
  `MFGBN_ASSERT_NEVER(a_wr_in_idle, clk, rst_n, tbl_req_o.wr_en && (state_r == FS_IDLE), "table written while idle")
  `MFGBN_ASSERT_NEVER(a_open_bound, clk, rst_n, open_r > OPEN_W'(FLOW_COUNT), "open flow count above table size")

endmodule

`default_nettype wire

/* design/mfgbn_back.sv */
// Back end: command queue and serialiser that hands out results one transfer at a time.
// Depends on mfgbn_pkg and the assertion macro header.
`default_nettype none
`include "multi_flow_go_back_n_receiver_top_defines.svh"

module mfgbn_back
  import mfgbn_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    cmd_valid_i,
  input  cmd_t    cmd_i,
  output logic    cmd_ready_o,
  output logic    empty_o,
  input  logic    pop_i,
  output result_t res_o,
  output logic    last_o
);

  cmd_t               q_r [CMDQ_DEPTH];
  logic [CMDQ_PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CMDQ_PW:0]   cnt_r, cnt_nxt;
  logic [1:0]         slot_r, slot_nxt;
  cmd_t               head;
  logic               push_go, pop_go, done_cmd;

  assign head        = q_r[rp_r];
  assign cmd_ready_o = (cnt_r != (CMDQ_PW+1)'(CMDQ_DEPTH));
  assign empty_o     = (cnt_r == '0);
  assign push_go     = cmd_valid_i && cmd_ready_o;
  assign pop_go      = pop_i && !empty_o;
  assign res_o       = head.res[slot_r];
  assign last_o      = (slot_r == (head.cnt - 2'd1));
  assign done_cmd    = pop_go && last_o;

  always_comb begin
    wp_nxt   = wp_r;
    rp_nxt   = rp_r;
    slot_nxt = slot_r;
    cnt_nxt  = cnt_r;
    if (push_go) begin
      wp_nxt = (wp_r == CMDQ_PW'(CMDQ_DEPTH - 1)) ? '0 : wp_r + CMDQ_PW'(1);
    end
    if (pop_go) begin
      // Advance through the command's results, then retire it
      if (last_o) begin
        slot_nxt = 2'd0;
        rp_nxt   = (rp_r == CMDQ_PW'(CMDQ_DEPTH - 1)) ? '0 : rp_r + CMDQ_PW'(1);
      end else begin
        slot_nxt = slot_r + 2'd1;
      end
    end
    case ({push_go, done_cmd})
      2'b10:   cnt_nxt = cnt_r + (CMDQ_PW+1)'(1);
      2'b01:   cnt_nxt = cnt_r - (CMDQ_PW+1)'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push_go) begin
      q_r[wp_r] <= cmd_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      rp_r   <= '0;
      cnt_r  <= '0;
      slot_r <= 2'd0;
    end else begin
      wp_r   <= wp_nxt;
      rp_r   <= rp_nxt;
      cnt_r  <= cnt_nxt;
      slot_r <= slot_nxt;
    end
  end

  `MFGBN_ASSERT_NEVER(a_q_over, clk, rst_n, cnt_r > (CMDQ_PW+1)'(CMDQ_DEPTH), "command queue overfilled")
  `MFGBN_ASSERT_NEVER(a_empty_cmd, clk, rst_n, push_go && (cmd_i.cnt == 2'd0), "command without results queued")
  `MFGBN_ASSERT_IMPLIES(a_slot_range, clk, rst_n, !empty_o, slot_r < head.cnt, "result slot beyond command")

endmodule

`default_nettype wire
